[src/button_debounce_autorepeat_defines.svh]
// shared assertion macros for the button front end
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define BDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define BDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bda_pkg.sv]
package bda_pkg;

  localparam int PIN_W  = 4;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam int IDX_W  = 2;

  localparam int UP_BIT   = 2;
  localparam int DOWN_BIT = 3;

  localparam logic [PIN_W-1:0] PIN_IDLE  = '1;
  localparam logic [PIN_W-1:0] UP_MASK   = PIN_W'(1) << UP_BIT;
  localparam logic [PIN_W-1:0] DOWN_MASK = PIN_W'(1) << DOWN_BIT;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(20);
  localparam logic [CFG_W-1:0] HOLD_RST     = CFG_W'(500);
  localparam logic [CFG_W-1:0] REPEAT_RST   = CFG_W'(100);

  // register indexes (word address)
  localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [IDX_W-1:0] REG_HOLD     = 2'd1;
  localparam logic [IDX_W-1:0] REG_REPEAT   = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] hold_ms;
    logic [CFG_W-1:0] repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic [PIN_W-1:0] stable;
    logic [PIN_W-1:0] press;
    logic [PIN_W-1:0] repeats;
  } res_t;

endpackage

[src/bda_regs.sv]
module bda_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bda_pkg::ADDR_W-1:0] paddr,
  input  logic [bda_pkg::DATA_W-1:0] pwdata,
  output logic [bda_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bda_pkg::cfg_t              cfg
);

  logic [bda_pkg::IDX_W-1:0] idx;
  logic                      wr_en;
  bda_pkg::cfg_t             cfg_reg;

  assign idx    = paddr[bda_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.debounce_ms <= bda_pkg::DEBOUNCE_RST;
      cfg_reg.hold_ms     <= bda_pkg::HOLD_RST;
      cfg_reg.repeat_ms   <= bda_pkg::REPEAT_RST;
    end else if (wr_en) begin
      unique case (idx)
        bda_pkg::REG_DEBOUNCE: cfg_reg.debounce_ms <= pwdata[bda_pkg::CFG_W-1:0];
        bda_pkg::REG_HOLD:     cfg_reg.hold_ms     <= pwdata[bda_pkg::CFG_W-1:0];
        bda_pkg::REG_REPEAT:   cfg_reg.repeat_ms   <= pwdata[bda_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bda_pkg::REG_DEBOUNCE: prdata = bda_pkg::DATA_W'(cfg_reg.debounce_ms);
      bda_pkg::REG_HOLD:     prdata = bda_pkg::DATA_W'(cfg_reg.hold_ms);
      bda_pkg::REG_REPEAT:   prdata = bda_pkg::DATA_W'(cfg_reg.repeat_ms);
      default:               prdata = '0;
    endcase
  end

endmodule

[src/bda_repeat.sv]
module bda_repeat (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [bda_pkg::TIME_W-1:0] now,
  input  logic                       fell,
  input  logic                       pressed,
  input  bda_pkg::cfg_t              cfg,
  output logic                       fire
);

  logic [bda_pkg::TIME_W-1:0] press_stamp;
  logic [bda_pkg::TIME_W-1:0] repeat_stamp;
  logic [bda_pkg::TIME_W-1:0] press_age;
  logic [bda_pkg::TIME_W-1:0] repeat_age;

  // a fresh press restamps both timers, so both ages read zero
  assign press_age  = fell ? '0 : now - press_stamp;
  assign repeat_age = fell ? '0 : now - repeat_stamp;

  assign fire = pressed
             && (press_age  >= bda_pkg::TIME_W'(cfg.hold_ms))
             && (repeat_age >= bda_pkg::TIME_W'(cfg.repeat_ms));

  always_ff @(posedge clk) begin
    if (rst) begin
      press_stamp  <= '0;
      repeat_stamp <= '0;
    end else if (step) begin
      if (fell) begin
        press_stamp <= now;
      end
      if (fell || fire) begin
        repeat_stamp <= now;
      end
    end
  end

endmodule

[src/bda_core.sv]
module bda_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [bda_pkg::PIN_W-1:0]  raw,
  input  logic [bda_pkg::TIME_W-1:0] now,
  input  logic [bda_pkg::PIN_W-1:0]  pack,
  input  logic [bda_pkg::PIN_W-1:0]  rack,
  input  bda_pkg::cfg_t              cfg,
  output bda_pkg::res_t              res
);

  logic [bda_pkg::PIN_W-1:0]  stable_levels;
  logic [bda_pkg::PIN_W-1:0]  previous_raw;
  logic [bda_pkg::PIN_W-1:0]  press_pending;
  logic [bda_pkg::PIN_W-1:0]  repeat_pending;
  logic [bda_pkg::TIME_W-1:0] change_stamp;

  logic [bda_pkg::TIME_W-1:0] quiet_age;
  logic                       settle;
  logic [bda_pkg::PIN_W-1:0]  fell;
  logic [bda_pkg::PIN_W-1:0]  stable_next;
  logic [bda_pkg::PIN_W-1:0]  press_next;
  logic [bda_pkg::PIN_W-1:0]  repeat_next;
  logic                       up_fire;
  logic                       down_fire;

  // a raw change restarts the shared debounce window at zero
  assign quiet_age = (raw != previous_raw) ? '0 : now - change_stamp;
  assign settle    = (quiet_age >= bda_pkg::TIME_W'(cfg.debounce_ms))
                  && (raw != stable_levels);
  assign fell        = settle ? (stable_levels & ~raw) : '0;
  assign stable_next = settle ? raw : stable_levels;

  bda_repeat u_up (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .now     (now),
    .fell    (|(fell & bda_pkg::UP_MASK)),
    .pressed (~|(stable_next & bda_pkg::UP_MASK)),
    .cfg     (cfg),
    .fire    (up_fire)
  );

  bda_repeat u_down (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .now     (now),
    .fell    (|(fell & bda_pkg::DOWN_MASK)),
    .pressed (~|(stable_next & bda_pkg::DOWN_MASK)),
    .cfg     (cfg),
    .fire    (down_fire)
  );

  // acks clear first, events of this request then set
  assign press_next  = (press_pending & ~pack) | fell;
  assign repeat_next = (repeat_pending & ~rack)
                     | (up_fire   ? bda_pkg::UP_MASK   : '0)
                     | (down_fire ? bda_pkg::DOWN_MASK : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_levels  <= bda_pkg::PIN_IDLE;
      previous_raw   <= bda_pkg::PIN_IDLE;
      press_pending  <= '0;
      repeat_pending <= '0;
      change_stamp   <= '0;
    end else if (step) begin
      stable_levels  <= stable_next;
      previous_raw   <= raw;
      press_pending  <= press_next;
      repeat_pending <= repeat_next;
      if (raw != previous_raw) begin
        change_stamp <= now;
      end
    end
  end

  assign res.stable  = stable_levels;
  assign res.press   = press_pending;
  assign res.repeats = repeat_pending;

endmodule

[src/button_debounce_autorepeat.sv]
// Debounced four-button front end with sticky press events and auto repeat.
// Each request carries the raw active-low pins, a free-running millisecond
// stamp and two acknowledge masks; each request yields exactly one result with
// the debounced levels, the pending press and repeat flags and the up/down held
// bits, all taken after that request's update. Acks clear flags before new
// events set them. Any raw change restarts one shared debounce window; after
// debounce_ms without change the raw vector becomes the stable vector and each
// high-to-low bit latches a press flag. The up (bit 2) and down (bit 3) buttons
// latch a repeat flag once hold_ms and repeat_ms have both passed since the
// press and every repeat_ms after that. All ages are taken modulo 2^32.
// Throughput is one request per clock while the result is not stalled; an
// accepted request sits in the input register until the result slot is
// free, then its debounce/timer update loads into the state registers,
// which double as the result register. A stalled result holds the state and
// the input register, so one more request waits behind it before req_stall
// rises. Registers sit at byte addresses 0 (debounce_ms), 4 (hold_ms) and
// 8 (repeat_ms), 16 bits each, and are to be written only while the block is
// idle.
`include "button_debounce_autorepeat_defines.svh"

module button_debounce_autorepeat (
  input  logic                       clk,
  input  logic                       rst,
  // apb configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bda_pkg::ADDR_W-1:0] paddr,
  input  logic [bda_pkg::DATA_W-1:0] pwdata,
  output logic [bda_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // request channel
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [bda_pkg::PIN_W-1:0]  raw_buttons,
  input  logic [bda_pkg::TIME_W-1:0] now_ms,
  input  logic [bda_pkg::PIN_W-1:0]  press_ack,
  input  logic [bda_pkg::PIN_W-1:0]  repeat_ack,
  // result channel
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [bda_pkg::PIN_W-1:0]  stable_buttons,
  output logic [bda_pkg::PIN_W-1:0]  press_flags,
  output logic [bda_pkg::PIN_W-1:0]  repeat_flags,
  output logic                       up_held,
  output logic                       down_held
);

  bda_pkg::cfg_t cfg;
  bda_pkg::res_t res;

  // input register
  logic                       s1_valid;
  logic [bda_pkg::PIN_W-1:0]  s1_raw;
  logic [bda_pkg::TIME_W-1:0] s1_now;
  logic [bda_pkg::PIN_W-1:0]  s1_pack;
  logic [bda_pkg::PIN_W-1:0]  s1_rack;

  logic res_free;
  logic step;
  logic req_take;

  bda_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the result slot frees when empty or being taken this cycle
  assign res_free  = !res_valid || !res_stall;
  // the held request updates the state (and so the result) only into a free slot
  assign step      = s1_valid && res_free;
  assign req_stall = s1_valid && !res_free;
  assign req_take  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_raw  <= raw_buttons;
      s1_now  <= now_ms;
      s1_pack <= press_ack;
      s1_rack <= repeat_ack;
    end
  end

  bda_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .raw  (s1_raw),
    .now  (s1_now),
    .pack (s1_pack),
    .rack (s1_rack),
    .cfg  (cfg),
    .res  (res)
  );

  // result valid tracks whether the state holds an undelivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= step;
    end
  end

  assign stable_buttons = res.stable;
  assign press_flags    = res.press;
  assign repeat_flags   = res.repeats;
  assign up_held        = ~|(res.stable & bda_pkg::UP_MASK);
  assign down_held      = ~|(res.stable & bda_pkg::DOWN_MASK);

  `BDA_ASSERT_NEXT(a_step_gives_result, step, res_valid,
    "processed request did not produce a result")
  `BDA_ASSERT_NEXT(a_state_holds_idle, !step,
    $stable(stable_buttons) && $stable(press_flags) && $stable(repeat_flags),
    "result state changed without a processed request")
  `BDA_ASSERT_NOW(a_repeat_only_updown, 1'b1,
    (repeat_flags & ~(bda_pkg::UP_MASK | bda_pkg::DOWN_MASK)) == '0,
    "repeat flag set on a button without auto repeat")

endmodule
